// ===== hdl/rcdc_pkg.sv =====
// Shared types, constants and the month-start table for the relative date classifier.
package rcdc_pkg;

  // Result label codes.
  typedef enum logic [2:0] {
    LK_TODAY          = 3'd0,
    LK_YESTERDAY      = 3'd1,
    LK_TOMORROW       = 3'd2,
    LK_LAST_WEEKDAY   = 3'd3,
    LK_THIS_WEEKDAY   = 3'd4,
    LK_MONTH_DAY      = 3'd5,
    LK_MONTH_DAY_YEAR = 3'd6
  } label_kind_t;

  // Pipeline shape: input stage, day stages, civil stages, output stage.
  localparam int DAY_LAT    = 3;
  localparam int CIVIL_LAT  = 11;
  localparam int PIPE_DEPTH = 1 + DAY_LAT + CIVIL_LAT + 1;

  // Seconds to days: shift by 7, then floor divide by 675 after a bias.
  localparam logic [33:0] DAY_BIAS    = 34'd4294967625;  // 675 * DAY_BIAS_Q
  localparam logic [23:0] DAY_BIAS_Q  = 24'd6362915;
  localparam logic [24:0] RECIP_675   = 25'd25451658;    // floor(2^34 / 675)
  localparam logic [9:0]  DIV_675     = 10'd675;

  // Day number to era-shifted day count: 719468 plus 64 eras.
  localparam logic [23:0] CIVIL_BIAS  = 24'd10069676;
  localparam logic [18:0] ERA_DAYS    = 19'd146097;
  localparam logic [15:0] ERA_YEAR_BIAS = 16'd25600;     // 64 eras of 400 years

  // Month start (153 * mp + 2) / 5 within a March-based year.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/rcdc_day.sv =====
// Three-stage floor division of signed seconds by 86400 into a day number.
module rcdc_day (
  input  logic               clk,
  input  logic               en,
  input  logic signed [39:0] secs,
  output logic        [23:0] day
);

  logic [33:0] u_next;
  logic [33:0] u1;
  logic [33:0] u2;
  logic [24:0] q0;
  logic [58:0] prod;
  logic [33:0] rem;
  logic [24:0] q;

  // Divide by 128 with an arithmetic shift, then bias to a positive value.
  assign u_next = {secs[39], secs[39:7]} + rcdc_pkg::DAY_BIAS;

  // Reciprocal estimate, low by at most one.
  assign prod = 59'(u1) * 59'(rcdc_pkg::RECIP_675);

  // Correct the estimate with one compare.
  assign rem = u2 - 34'(35'(q0) * 35'(rcdc_pkg::DIV_675));
  assign q   = q0 + {24'd0, (rem >= 34'(rcdc_pkg::DIV_675))};

  always_ff @(posedge clk) begin
    if (en) begin
      u1  <= u_next;
      u2  <= u1;
      q0  <= prod[58:34];
      day <= q[23:0] - rcdc_pkg::DAY_BIAS_Q;
    end
  end

endmodule

// ===== hdl/rcdc_civil.sv =====
// Eleven-stage proleptic Gregorian conversion of a day number to year, month, day and weekday.
module rcdc_civil (
  input  logic        clk,
  input  logic        en,
  input  logic [23:0] day,
  output logic [15:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [2:0]  weekday
);

  logic [23:0] zz1, zz2;
  logic [30:0] eprod;
  logic [6:0]  e0_2, e3, e4, e5, e6, e7, e8, e9, e10;
  logic [23:0] wx;
  logic [5:0]  osum;
  logic [5:0]  s2;
  logic [3:0]  wsum;
  logic [2:0]  w3, w4, w5, w6, w7, w8, w9, w10;
  logic [18:0] erem;
  logic        ege;
  logic [17:0] doe3, doe4, doe5, doe6, doe7;
  logic [25:0] aprod;
  logic [20:0] bprod;
  logic [7:0]  a0_4, a5;
  logic [2:0]  b0_4, b5;
  logic [17:0] ra, rb, n5, n6;
  logic [27:0] yprod;
  logic [8:0]  y0_6, yoe7, yoe8, yoe9, yoe10;
  logic [1:0]  c100;
  logic [17:0] ybase;
  logic [8:0]  doy8, doy9, doy10;
  logic [10:0] v8, v9;
  logic [14:0] mprod;
  logic [3:0]  mp0_9, mp10;
  logic [10:0] rmp;
  logic [3:0]  m_next;
  logic [8:0]  dom;

  // Stage 1 input: shift into a positive era-based day count.
  // Stage 2: era estimate and octal digit sum for the weekday.
  assign eprod = 31'(zz1) * 31'(114);
  assign wx    = zz1 + 24'd3;
  always_comb begin
    osum = '0;
    for (int k = 0; k < 8; k++) begin
      osum = osum + 6'(wx[3*k +: 3]);
    end
  end

  // Stage 3: era correction and weekday reduction modulo seven.
  assign erem = 19'(zz2) - 19'(26'(e0_2) * 26'(rcdc_pkg::ERA_DAYS));
  assign ege  = (erem >= rcdc_pkg::ERA_DAYS);
  assign wsum = {1'b0, s2[5:3]} + {1'b0, s2[2:0]};

  // Stage 4: estimates of doe / 1460 and doe / 36524.
  assign aprod = 26'(doe3) * 26'(179);
  assign bprod = 21'(doe3) * 21'(7);

  // Stage 5: correct both quotients and form the year-of-era numerator.
  assign ra = doe4 - 18'(18'(a0_4) * 18'(1460));
  assign rb = doe4 - 18'(18'(b0_4) * 18'(36524));

  // Stage 6 and 7: year of era by reciprocal and correction.
  assign yprod = 28'(n5) * 28'(718);

  // Stage 8: day of year.
  always_comb begin
    priority if (yoe7 >= 9'd300) c100 = 2'd3;
    else if (yoe7 >= 9'd200)     c100 = 2'd2;
    else if (yoe7 >= 9'd100)     c100 = 2'd1;
    else                         c100 = 2'd0;
  end
  assign ybase = 18'(18'(yoe7) * 18'(365)) + 18'(yoe7[8:2]) - 18'(c100);

  // Stage 9 and 10: March-based month index.
  assign v8    = 11'(11'(doy8) * 11'(5)) + 11'd2;
  assign mprod = 15'(v8) * 15'(13);
  assign v9    = 11'(11'(doy9) * 11'(5)) + 11'd2;
  assign rmp   = v9 - 11'(11'(mp0_9) * 11'(153));

  // Stage 11: civil month, day and year.
  assign m_next = (mp10 < 4'd10) ? mp10 + 4'd3 : mp10 - 4'd9;
  assign dom    = doy10 - rcdc_pkg::month_start(mp10) + 9'd1;

  logic [17:0] n6_rem;
  assign n6_rem = n6 - 18'(18'(y0_6) * 18'(365));

  always_ff @(posedge clk) begin
    if (en) begin
      zz1  <= day + rcdc_pkg::CIVIL_BIAS;
      zz2  <= zz1;
      e0_2 <= eprod[30:24];
      s2   <= osum;

      e3   <= e0_2 + 7'(ege);
      doe3 <= ege ? 18'(erem - rcdc_pkg::ERA_DAYS) : erem[17:0];
      if (wsum >= 4'd14) begin
        w3 <= 3'(wsum - 4'd14);
      end else if (wsum >= 4'd7) begin
        w3 <= 3'(wsum - 4'd7);
      end else begin
        w3 <= wsum[2:0];
      end

      a0_4 <= aprod[25:18];
      b0_4 <= bprod[20:18];
      doe4 <= doe3;
      e4   <= e3;
      w4   <= w3;

      n5   <= doe4 - 18'(a5) + 18'(b5) - 18'(doe4 == 18'd146096);
      doe5 <= doe4;
      e5   <= e4;
      w5   <= w4;

      n6   <= n5;
      y0_6 <= yprod[26:18];
      doe6 <= doe5;
      e6   <= e5;
      w6   <= w5;

      yoe7 <= y0_6 + 9'(n6_rem >= 18'd365);
      doe7 <= doe6;
      e7   <= e6;
      w7   <= w6;

      doy8 <= 9'(doe7 - ybase);
      yoe8 <= yoe7;
      e8   <= e7;
      w8   <= w7;

      mp0_9 <= mprod[14:11];
      doy9  <= doy8;
      yoe9  <= yoe8;
      e9    <= e8;
      w9    <= w8;

      mp10  <= mp0_9 + 4'(rmp >= 11'd153);
      doy10 <= doy9;
      yoe10 <= yoe9;
      e10   <= e9;
      w10   <= w9;

      month        <= m_next;
      day_of_month <= dom[4:0];
      weekday      <= w10;
      year         <= 16'(yoe10) + 16'(16'(e10) * 16'(400)) - rcdc_pkg::ERA_YEAR_BIAS
                      + 16'(m_next <= 4'd2);
    end
  end

  // Quotient corrections for stage 5.
  assign a5 = a0_4 + 8'(ra >= 18'd1460);
  assign b5 = b0_4 + 3'(rb >= 18'd36524);

endmodule

// ===== hdl/relative_calendar_date_classifier_top.sv =====
// Sixteen-stage pipeline of the relative calendar date classifier.
// Each item carries an event time and an optional reference time in whole Unix seconds and
// returns one result: a relative label (today, yesterday, tomorrow, a weekday within six days
// back or ahead, or a plain date, with the year only when the reference year differs) plus the
// event's weekday, civil month, day of month and year. An item is accepted every cycle while
// the output is not stalled; the depth is set by the chain of constant-reciprocal divisions,
// one multiply and its correction per stage pair. A stall on the output freezes the whole
// pipeline, so in_ready follows out_ready whenever a result is waiting.
module relative_calendar_date_classifier_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [39:0] event_seconds,
  input  logic signed [39:0] reference_seconds,
  input  logic               has_reference,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [2:0]  label_kind,
  output logic        [2:0]  weekday,
  output logic        [3:0]  month,
  output logic        [4:0]  day_of_month,
  output logic signed [15:0] year
);

  logic                               en;
  logic [rcdc_pkg::PIPE_DEPTH-1:0]    vld;
  logic signed [39:0]                 ev0;
  logic signed [39:0]                 rf0;
  logic [23:0]                        day_ev;
  logic [23:0]                        day_rf;
  logic signed [24:0]                 diff;
  rcdc_pkg::label_kind_t              kind_pre;
  rcdc_pkg::label_kind_t              kind_dly [rcdc_pkg::CIVIL_LAT];
  logic [15:0]                        ev_year;
  logic [15:0]                        rf_year;
  logic [3:0]                         ev_month;
  logic [4:0]                         ev_dom;
  logic [2:0]                         ev_wday;

  // The pipeline advances whenever the output slot is free or being emptied.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[rcdc_pkg::PIPE_DEPTH-1];

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[rcdc_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  // Input stage: resolve the reference time.
  always_ff @(posedge clk) begin
    if (en) begin
      ev0 <= event_seconds;
      rf0 <= has_reference ? reference_seconds : event_seconds;
    end
  end

  rcdc_day u_day_ev (.clk(clk), .en(en), .secs(ev0), .day(day_ev));
  rcdc_day u_day_rf (.clk(clk), .en(en), .secs(rf0), .day(day_rf));

  rcdc_civil u_civil_ev (
    .clk(clk), .en(en), .day(day_ev),
    .year(ev_year), .month(ev_month), .day_of_month(ev_dom), .weekday(ev_wday)
  );

  rcdc_civil u_civil_rf (
    .clk(clk), .en(en), .day(day_rf),
    .year(rf_year), .month(), .day_of_month(), .weekday()
  );

  // Classify the day difference; plain dates are resolved once the years are known.
  assign diff = {day_ev[23], day_ev} - {day_rf[23], day_rf};
  always_comb begin
    priority if (diff == 25'sd0)                   kind_pre = rcdc_pkg::LK_TODAY;
    else if (diff == -25'sd1)                      kind_pre = rcdc_pkg::LK_YESTERDAY;
    else if (diff == 25'sd1)                       kind_pre = rcdc_pkg::LK_TOMORROW;
    else if (diff >= -25'sd6 && diff <= -25'sd2)   kind_pre = rcdc_pkg::LK_LAST_WEEKDAY;
    else if (diff >= 25'sd2 && diff <= 25'sd6)     kind_pre = rcdc_pkg::LK_THIS_WEEKDAY;
    else                                           kind_pre = rcdc_pkg::LK_MONTH_DAY;
  end

  // Delay the label to line up with the civil conversion.
  always_ff @(posedge clk) begin
    if (en) begin
      kind_dly[0] <= kind_pre;
      for (int i = 1; i < rcdc_pkg::CIVIL_LAT; i++) begin
        kind_dly[i] <= kind_dly[i-1];
      end
    end
  end

  // Output stage.
  always_ff @(posedge clk) begin
    if (en) begin
      if (kind_dly[rcdc_pkg::CIVIL_LAT-1] == rcdc_pkg::LK_MONTH_DAY && ev_year != rf_year) begin
        label_kind <= rcdc_pkg::LK_MONTH_DAY_YEAR;
      end else begin
        label_kind <= kind_dly[rcdc_pkg::CIVIL_LAT-1];
      end
      weekday      <= ev_wday;
      month        <= ev_month;
      day_of_month <= ev_dom;
      year         <= ev_year;
    end
  end

  // A delivered result has a month from 1 to 12 and a nonzero day of month.
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1 && month <= 4'd12 && day_of_month != 5'd0))
    else $error("month or day of month out of range");

  a_feb_days: assert property (@(posedge clk) disable iff (rst)
    (out_valid && month == 4'd2) |-> day_of_month <= 5'd29)
    else $error("February day beyond 29");

  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weekday <= 3'd6 && label_kind <= 3'd6))
    else $error("weekday or label code out of range");

endmodule

// ===== tb/sv/relative_calendar_date_classifier_top_tb.sv =====
// Self-checking testbench for the relative calendar date classifier pipeline.
`timescale 1ns / 1ps

module relative_calendar_date_classifier_top_tb;

  localparam int N_RANDOM = 530;
  localparam int SECS_DAY = 86400;
  localparam longint MIN40 = -64'sd549755813888;
  localparam longint MAX40 = 64'sd549755813887;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [39:0] event_seconds = '0;
  logic signed [39:0] reference_seconds = '0;
  logic has_reference = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] label_kind;
  logic [2:0] weekday;
  logic [3:0] month;
  logic [4:0] day_of_month;
  logic signed [15:0] year;

  typedef struct packed {
    rcdc_pkg::label_kind_t kind;
    logic [2:0] wday;
    logic [3:0] mon;
    logic [4:0] mday;
    logic signed [15:0] yr;
  } date_label_t;

  // One directed row; want_known marks a result typed in by hand.
  typedef struct {
    longint ev;
    longint rf;
    bit has_ref;
    bit want_known;
    date_label_t want;
  } stim_row_t;

  date_label_t pending_labels[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  relative_calendar_date_classifier_top u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .event_seconds(event_seconds), .reference_seconds(reference_seconds),
    .has_reference(has_reference), .out_valid(out_valid), .out_ready(out_ready),
    .label_kind(label_kind), .weekday(weekday), .month(month),
    .day_of_month(day_of_month), .year(year)
  );

  always #10 clk = ~clk;

  // Floor division of seconds into a day number.
  function automatic longint day_number(longint s);
    longint q;
    q = s / SECS_DAY;
    if (s % SECS_DAY < 0) q = q - 1;
    return q;
  endfunction

  // Proleptic Gregorian civil date of a day number.
  function automatic void civil_date(longint z, output longint y, output longint m,
                                     output longint d);
    longint era, doe, yoe, doy, mp;
    z = z + 719468;
    era = (z >= 0 ? z : z - 146096) / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    d = doy - (153 * mp + 2) / 5 + 1;
    m = (mp < 10) ? mp + 3 : mp - 9;
    y = yoe + era * 400 + (m <= 2 ? 1 : 0);
  endfunction

  function automatic date_label_t classify_date(longint ev, longint rf, bit has_ref);
    date_label_t r;
    longint ed, rd, diff, y, m, d, ry, rm, rdd, w;
    ed = day_number(ev);
    rd = has_ref ? day_number(rf) : ed;
    diff = ed - rd;
    civil_date(ed, y, m, d);
    civil_date(rd, ry, rm, rdd);
    if (diff == 0) r.kind = rcdc_pkg::LK_TODAY;
    else if (diff == -1) r.kind = rcdc_pkg::LK_YESTERDAY;
    else if (diff == 1) r.kind = rcdc_pkg::LK_TOMORROW;
    else if (diff >= -6 && diff <= -2) r.kind = rcdc_pkg::LK_LAST_WEEKDAY;
    else if (diff >= 2 && diff <= 6) r.kind = rcdc_pkg::LK_THIS_WEEKDAY;
    else if (y == ry) r.kind = rcdc_pkg::LK_MONTH_DAY;
    else r.kind = rcdc_pkg::LK_MONTH_DAY_YEAR;
    w = (ed + 4) % 7;
    if (w < 0) w = w + 7;
    r.wday = w[2:0];
    r.mon = m[3:0];
    r.mday = d[4:0];
    r.yr = y[15:0];
    return r;
  endfunction

  function automatic longint rand40();
    return longint'({$urandom(), $urandom()}) <<< 24 >>> 24;
  endfunction

  function automatic stim_row_t mk_row(longint ev, longint rf, bit h);
    stim_row_t r;
    r.ev = ev; r.rf = rf; r.has_ref = h; r.want_known = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t mk_known(longint ev, longint rf, bit h,
                                         rcdc_pkg::label_kind_t k,
                                         int wd, int mo, int md, int yr);
    stim_row_t r;
    r = mk_row(ev, rf, h);
    r.want_known = 1'b1;
    r.want.kind = k; r.want.wday = wd[2:0]; r.want.mon = mo[3:0];
    r.want.mday = md[4:0]; r.want.yr = yr[15:0];
    return r;
  endfunction

  // Hold one item until accepted, with random sender gaps.
  task automatic send_item(longint ev, longint rf, bit h, date_label_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pending_labels.push_back(want);
    in_valid <= 1'b1;
    event_seconds <= ev[39:0];
    reference_seconds <= rf[39:0];
    has_reference <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_checked(longint ev, longint rf, bit h);
    send_item(ev, rf, h, classify_date(ev, rf, h));
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    date_label_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_labels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind=%0d", label_kind);
      end else begin
        want = pending_labels.pop_front();
        if (label_kind !== want.kind || weekday !== want.wday || month !== want.mon ||
            day_of_month !== want.mday || year !== want.yr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp k=%0d w=%0d %0d/%0d/%0d got k=%0d w=%0d %0d/%0d/%0d",
                     want.kind, want.wday, want.mon, want.mday, want.yr,
                     label_kind, weekday, month, day_of_month, year);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("relative_calendar_date_classifier_top_tb failed");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    longint ev, rf, base;
    int pick, wait_cycles;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: epoch, field extremes, the ignored reference and each label.
    rows.push_back(mk_known(0, 0, 1'b0, rcdc_pkg::LK_TODAY, 4, 1, 1, 1970));
    rows.push_back(mk_known(-1, 0, 1'b1, rcdc_pkg::LK_YESTERDAY, 3, 12, 31, 1969));
    rows.push_back(mk_known(86400, 0, 1'b1, rcdc_pkg::LK_TOMORROW, 5, 1, 2, 1970));
    rows.push_back(mk_known(0, MAX40, 1'b0, rcdc_pkg::LK_TODAY, 4, 1, 1, 1970));
    rows.push_back(mk_known(0, 3 * 86400, 1'b1, rcdc_pkg::LK_LAST_WEEKDAY, 4, 1, 1, 1970));
    rows.push_back(mk_known(5 * 86400, 0, 1'b1, rcdc_pkg::LK_THIS_WEEKDAY, 2, 1, 6, 1970));
    rows.push_back(mk_known(10 * 86400, 0, 1'b1, rcdc_pkg::LK_MONTH_DAY, 0, 1, 11, 1970));
    rows.push_back(mk_known(0, -1, 1'b1, rcdc_pkg::LK_TOMORROW, 4, 1, 1, 1970));
    rows.push_back(mk_row(MIN40, MAX40, 1'b1));
    rows.push_back(mk_row(MAX40, MIN40, 1'b1));
    rows.push_back(mk_row(MIN40, MIN40, 1'b0));
    rows.push_back(mk_row(MAX40, 0, 1'b1));
    rows.push_back(mk_row(-86401, 0, 1'b1));
    rows.push_back(mk_row(-6 * 86400, 0, 1'b1));
    rows.push_back(mk_row(-7 * 86400, 0, 1'b1));
    rows.push_back(mk_row(6 * 86400 + 86399, 0, 1'b1));
    rows.push_back(mk_row(951782400, 0, 1'b1));    // leap day in a century leap year
    rows.push_back(mk_row(-2203977600, 0, 1'b1));  // end of February in a non-leap century
    rows.push_back(mk_row(-62135596800, 0, 1'b1)); // start of year one
    rows.push_back(mk_row(1704067199, 1704067200, 1'b1)); // across a year boundary
    rows.push_back(mk_row(-1, -2, 1'b1));
    foreach (rows[i]) begin
      if (rows[i].want_known) send_item(rows[i].ev, rows[i].rf, rows[i].has_ref, rows[i].want);
      else send_checked(rows[i].ev, rows[i].rf, rows[i].has_ref);
    end

    // Random items in three idling phases.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 0) begin send_idle_pct = 16; recv_idle_pct = 58; end
      if (n == N_RANDOM / 3) begin send_idle_pct = 58; recv_idle_pct = 16; end
      if (n == 2 * N_RANDOM / 3) begin send_idle_pct = 0; recv_idle_pct = 0; end
      pick = $urandom_range(9);
      if (pick < 2) begin
        ev = rand40(); rf = rand40();
      end else if (pick < 7) begin
        // Nearby reference: exercise the relative labels and year edges.
        base = longint'($urandom_range(20000)) * 31536000 / 100 - 64'sd3153600000;
        ev = base + $urandom_range(16 * SECS_DAY) - 8 * SECS_DAY;
        rf = base;
      end else begin
        ev = longint'($urandom()) - 64'sd2147483648;
        rf = ev + longint'($urandom_range(800)) * SECS_DAY - 400 * SECS_DAY;
      end
      send_checked(ev, rf, $urandom_range(7) != 0);
    end
    in_valid <= 1'b0;

    while (pending_labels.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 4 * rcdc_pkg::PIPE_DEPTH) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (mismatches == 0) $display("relative_calendar_date_classifier_top_tb passed");
    else $display("relative_calendar_date_classifier_top_tb failed");
    $finish;
  end

endmodule
